FILE: src/acpc_pkg.sv
// acpc_pkg: shared types and constants for the argmax class palette colorizer
// used by every design module of the block; no dependencies

`timescale 1ns / 1ps

package acpc_pkg;

  localparam int MaxClasses  = 16;
  localparam int ScoreW      = 8;
  localparam int ClassW      = $clog2(MaxClasses);
  localparam int ColourW     = 8;
  localparam int PalWords    = 6;
  localparam int PalWordW    = 64;
  localparam int PalBits     = PalWords * PalWordW;
  localparam int CfgAddrW    = $clog2(PalWords * 8);
  localparam int CfgIdxW     = CfgAddrW - 3;
  localparam int DefClasses  = 16;

  typedef logic [ScoreW-1:0]      score_t;
  typedef logic [ClassW-1:0]      class_t;
  typedef logic [ColourW-1:0]     colour_t;
  typedef logic [PalBits-1:0]     palette_t;
  typedef logic [PalWordW-1:0]    pal_word_t;

  // one finished pixel
  typedef struct packed {
    colour_t colour_first;
    colour_t colour_second;
    colour_t colour_third;
    class_t  class_index;
    logic    last_pixel;
  } result_t;

endpackage

FILE: src/acpc_cfg_regs.sv
// acpc_cfg_regs: apb-style register file holding the six 64-bit palette words
// depends on acpc_pkg

`timescale 1ns / 1ps

module acpc_cfg_regs
  import acpc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [PalWordW-1:0] pwdata,
  output logic [PalWordW-1:0] prdata,
  output logic                pready,
  output palette_t            palette
);

  pal_word_t            pal_r [PalWords];
  logic [CfgIdxW-1:0]   reg_idx;
  logic                 idx_ok;
  logic                 wr_en;

  // registers sit on 8-byte boundaries
  assign reg_idx = paddr[CfgAddrW-1:3];
  assign idx_ok  = (reg_idx < CfgIdxW'(PalWords));
  assign wr_en   = psel && penable && pwrite && idx_ok;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < PalWords; w++) begin
        pal_r[w] <= '0;
      end
    end else if (wr_en) begin
      pal_r[reg_idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = pal_r[reg_idx];
    end
  end

  // byte k of the palette sits at bits 8k+7..8k
  always_comb begin
    for (int w = 0; w < PalWords; w++) begin
      palette[w*PalWordW +: PalWordW] = pal_r[w];
    end
  end

endmodule

FILE: src/acpc_argmax.sv
// acpc_argmax: signed argmax over the class scores as a four-level compare tree
// depends on acpc_pkg

`timescale 1ns / 1ps

module acpc_argmax
  import acpc_pkg::*;
#(
  parameter int NUM_CLASSES = DefClasses
) (
  input  logic [MaxClasses*ScoreW-1:0] scores,
  output class_t                       best_idx
);

  localparam int Levels = ClassW;

  score_t node_val [Levels+1][MaxClasses];
  class_t node_idx [Levels+1][MaxClasses];
  logic   node_ok  [Levels+1][MaxClasses];

  always_comb begin
    for (int lv = 0; lv <= Levels; lv++) begin
      for (int j = 0; j < MaxClasses; j++) begin
        node_val[lv][j] = '0;
        node_idx[lv][j] = '0;
        node_ok[lv][j]  = 1'b0;
      end
    end
    // leaves: classes at or above NUM_CLASSES drop out
    for (int j = 0; j < MaxClasses; j++) begin
      node_val[0][j] = scores[j*ScoreW +: ScoreW];
      node_idx[0][j] = ClassW'(j);
      node_ok[0][j]  = (j < NUM_CLASSES) || (j == 0);
    end
    // right side wins only on strictly greater, so ties keep the lower index
    for (int lv = 0; lv < Levels; lv++) begin
      for (int j = 0; j < (MaxClasses >> (lv + 1)); j++) begin
        if (node_ok[lv][2*j+1] &&
            (!node_ok[lv][2*j] ||
             ($signed(node_val[lv][2*j+1]) > $signed(node_val[lv][2*j])))) begin
          node_val[lv+1][j] = node_val[lv][2*j+1];
          node_idx[lv+1][j] = node_idx[lv][2*j+1];
        end else begin
          node_val[lv+1][j] = node_val[lv][2*j];
          node_idx[lv+1][j] = node_idx[lv][2*j];
        end
        node_ok[lv+1][j] = node_ok[lv][2*j] || node_ok[lv][2*j+1];
      end
    end
  end

  assign best_idx = node_idx[Levels][0];

endmodule

FILE: src/acpc_palette_lut.sv
// acpc_palette_lut: picks the three colour bytes of one class from the palette
// depends on acpc_pkg

`timescale 1ns / 1ps

module acpc_palette_lut
  import acpc_pkg::*;
(
  input  palette_t palette,
  input  class_t   class_idx,
  output colour_t  colour_first,
  output colour_t  colour_second,
  output colour_t  colour_third
);

  logic [3*ColourW-1:0] entry;

  // class c owns palette bytes 3c .. 3c+2
  always_comb begin
    entry = '0;
    for (int c = 0; c < MaxClasses; c++) begin
      if (class_idx == ClassW'(c)) begin
        entry = palette[c*3*ColourW +: 3*ColourW];
      end
    end
  end

  assign colour_first  = entry[0*ColourW +: ColourW];
  assign colour_second = entry[1*ColourW +: ColourW];
  assign colour_third  = entry[2*ColourW +: ColourW];

endmodule

FILE: src/argmax_class_palette_colorizer.sv
// argmax_class_palette_colorizer: top level, input and result registers
// depends on acpc_pkg, acpc_cfg_regs, acpc_argmax, acpc_palette_lut

`timescale 1ns / 1ps

// Takes one pixel of sixteen signed 8-bit class scores per clock whenever start
// is high (busy is always low) and returns the colour of the highest-scoring
// class, lowest index on ties, with out_valid high. One pixel per cycle is
// sustained: a pixel passes an input register, a compare tree plus palette mux,
// and a result register, with nothing shared between pixels. The receiver
// cannot stall, so results must be taken in the cycle they appear. The palette
// is six 64-bit words at byte addresses 0, 8, .. 40 and resets to zero; write
// it only while no pixel is in flight.

module argmax_class_palette_colorizer
  import acpc_pkg::*;
#(
  parameter int NUM_CLASSES = DefClasses
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [PalWordW-1:0] pwdata,
  output logic [PalWordW-1:0] prdata,
  output logic                pready,
  input  logic                start,
  output logic                busy,
  input  logic [63:0]         in_scores_low,
  input  logic [63:0]         in_scores_high,
  input  logic                in_last_pixel,
  output logic                out_valid,
  output logic [7:0]          out_colour_first,
  output logic [7:0]          out_colour_second,
  output logic [7:0]          out_colour_third,
  output logic [3:0]          out_class_index,
  output logic                out_last_pixel_out
);

  palette_t                      palette;
  logic                          in_vld_r;
  logic [MaxClasses*ScoreW-1:0]  scores_r;
  logic                          last_r;
  class_t                        best_idx;
  colour_t                       lut_first;
  colour_t                       lut_second;
  colour_t                       lut_third;
  result_t                       res_nxt;
  result_t                       res_r;
  logic                          out_vld_r;

  assign busy = 1'b0;

  acpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .palette (palette)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      scores_r <= {in_scores_high, in_scores_low};
      last_r   <= in_last_pixel;
    end
  end

  acpc_argmax #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_argmax (
    .scores   (scores_r),
    .best_idx (best_idx)
  );

  acpc_palette_lut u_lut (
    .palette       (palette),
    .class_idx     (best_idx),
    .colour_first  (lut_first),
    .colour_second (lut_second),
    .colour_third  (lut_third)
  );

  assign res_nxt = {lut_first, lut_second, lut_third, best_idx, last_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_colour_first   = res_r.colour_first;
  assign out_colour_second  = res_r.colour_second;
  assign out_colour_third   = res_r.colour_third;
  assign out_class_index    = res_r.class_index;
  assign out_last_pixel_out = res_r.last_pixel;

endmodule

FILE: src/acpc_checker.sv
// acpc_checker: port-level assertions for the colorizer, bound to the top level
// depends on argmax_class_palette_colorizer

`timescale 1ns / 1ps

module acpc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last_pixel,
  input logic out_valid,
  input logic out_last_pixel_out,
  input logic pready
);

  // every accepted word comes out, after the input and result registers
  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted word produced no result");

  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without an accepted word");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_pixel_out == $past(in_last_pixel, 2)))
    else $error("last-pixel flag not carried with its word");

  a_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && pready)
    else $error("block stalled input or config port");

endmodule

bind argmax_class_palette_colorizer acpc_checker u_acpc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_last_pixel      (in_last_pixel),
  .out_valid          (out_valid),
  .out_last_pixel_out (out_last_pixel_out),
  .pready             (pready)
);

FILE: verif/acpc_checker.sv
// acpc_scoreboard: passive monitor for the argmax class palette colorizer
// keeps a palette copy, checks its reads, predicts the colour word of every
// accepted pixel and compares it with the result port; depends on acpc_pkg

`timescale 1ns / 1ps

module acpc_scoreboard
  import acpc_pkg::*;
#(
  parameter int NUM_CLASSES = DefClasses
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [PalWordW-1:0] pwdata,
  input  logic [PalWordW-1:0] prdata,
  input  logic                pready,
  input  logic                start,
  input  logic                busy,
  input  logic [63:0]         in_scores_low,
  input  logic [63:0]         in_scores_high,
  input  logic                in_last_pixel,
  input  logic                out_valid,
  input  logic [7:0]          out_colour_first,
  input  logic [7:0]          out_colour_second,
  input  logic [7:0]          out_colour_third,
  input  logic [3:0]          out_class_index,
  input  logic                out_last_pixel_out,
  output int                  fail_count,
  output int                  words_in_flight
);

  pal_word_t palette_copy [PalWords];
  result_t   pending_colours [$];

  // signed argmax, first index kept on ties
  function automatic class_t winning_class(logic [63:0] lo, logic [63:0] hi);
    logic [127:0]             all_scores;
    logic signed [ScoreW-1:0] best_score;
    logic signed [ScoreW-1:0] score;
    class_t                   best;
    all_scores = {hi, lo};
    best       = '0;
    best_score = all_scores[ScoreW-1:0];
    for (int k = 1; k < NUM_CLASSES && k < MaxClasses; k++) begin
      score = all_scores[ScoreW*k +: ScoreW];
      if (score > best_score) begin
        best_score = score;
        best       = class_t'(k);
      end
    end
    return best;
  endfunction

  function automatic colour_t palette_byte(int unsigned idx);
    return palette_copy[idx / 8][8*(idx % 8) +: 8];
  endfunction

  function automatic result_t colour_pixel(logic [63:0] lo, logic [63:0] hi, logic last);
    result_t want;
    want.class_index   = winning_class(lo, hi);
    want.colour_first  = palette_byte(int'(want.class_index) * 3);
    want.colour_second = palette_byte(int'(want.class_index) * 3 + 1);
    want.colour_third  = palette_byte(int'(want.class_index) * 3 + 2);
    want.last_pixel    = last;
    return want;
  endfunction

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    result_t fresh;
    int      cfg_idx;
    if (!rst_n) begin
      for (int i = 0; i < PalWords; i++) palette_copy[i] = '0;
      pending_colours.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pready) begin
        cfg_idx = int'(paddr[CfgAddrW-1:3]);
        if (pwrite) begin
          // words past the palette are dropped
          if (cfg_idx < PalWords) palette_copy[cfg_idx] = pwdata;
        end else if (cfg_idx < PalWords && prdata !== palette_copy[cfg_idx]) begin
          $display("%0t palette read word %0d expected %016h got %016h",
                   $time, cfg_idx, palette_copy[cfg_idx], prdata);
          fail_count++;
        end
      end
      if (out_valid === 1'b1) begin
        seen = '{out_colour_first, out_colour_second, out_colour_third,
                 out_class_index, out_last_pixel_out};
        if (pending_colours.size() == 0) begin
          $display("%0t unexpected word: colour %02h %02h %02h class %0d last %0b",
                   $time, seen.colour_first, seen.colour_second, seen.colour_third,
                   seen.class_index, seen.last_pixel);
          fail_count++;
        end else begin
          want = pending_colours.pop_front();
          if (seen !== want) begin
            $display("%0t mismatch expected colour %02h %02h %02h class %0d last %0b",
                     $time, want.colour_first, want.colour_second, want.colour_third,
                     want.class_index, want.last_pixel,
                     ", got colour %02h %02h %02h class %0d last %0b",
                     seen.colour_first, seen.colour_second, seen.colour_third,
                     seen.class_index, seen.last_pixel);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        fresh = colour_pixel(in_scores_low, in_scores_high, in_last_pixel);
        pending_colours = {pending_colours, fresh};
      end
    end
    words_in_flight = pending_colours.size();
  end

endmodule

FILE: verif/tb.sv
// tb: stimulus and verdict for the argmax class palette colorizer
// drives pixels, palette writes and reads, acpc_scoreboard compares; needs acpc_pkg

`timescale 1ns / 1ps

module tb;
  import acpc_pkg::*;

  localparam int NumClasses  = DefClasses;
  localparam int CycleLimit  = 500000;
  localparam int Drain       = 8;
  localparam int NumPhases   = 6;
  localparam int PhaseItems  = 285;
  localparam int NumDirected = 15;

  localparam logic [7:0] ExtremeScores [6] = '{8'h80, 8'h7f, 8'h00, 8'hff, 8'h01, 8'h81};

  localparam logic [63:0] DirLow [NumDirected] = '{
    64'h0000000000000000, 64'h8080808080808080, 64'h7f7f7f7f7f7f7f7f,
    64'hffffffffffffffff, 64'h8080808080808080, 64'h7f80808080808080,
    64'h8080808080808080, 64'h0f0f0f0f100f0f0f, 64'hfefefffefefefefe,
    64'h8080808080807f80, 64'h808080808080807f, 64'h9090909090909090,
    64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 64'h0123456789abcdef
  };
  localparam logic [63:0] DirHigh [NumDirected] = '{
    64'h0000000000000000, 64'h8080808080808080, 64'h7f7f7f7f7f7f7f7f,
    64'hffffffffffffffff, 64'h7f80808080808080, 64'h8080808080808080,
    64'h808080808080807f, 64'h0f0f0f100f0f0f0f, 64'hfefefefefefefefe,
    64'h8080808080808080, 64'h7f7f7f7f7f7f7f7f, 64'h9090909090fe9090,
    64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 64'hfedcba9876543210
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [PalWordW-1:0] pwdata = '0;
  logic [PalWordW-1:0] prdata;
  logic                pready;
  logic                start = 1'b0;
  logic                busy;
  logic [63:0]         in_scores_low = '0;
  logic [63:0]         in_scores_high = '0;
  logic                in_last_pixel = 1'b0;
  logic                out_valid;
  logic [7:0]          out_colour_first;
  logic [7:0]          out_colour_second;
  logic [7:0]          out_colour_third;
  logic [3:0]          out_class_index;
  logic                out_last_pixel_out;
  int                  fail_count;
  int                  words_in_flight;
  int unsigned         cycle_count = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  argmax_class_palette_colorizer #(.NUM_CLASSES(NumClasses)) dut (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .in_scores_low, .in_scores_high, .in_last_pixel,
    .out_valid, .out_colour_first, .out_colour_second, .out_colour_third,
    .out_class_index, .out_last_pixel_out
  );

  acpc_scoreboard #(.NUM_CLASSES(NumClasses)) colour_check (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .in_scores_low, .in_scores_high, .in_last_pixel,
    .out_valid, .out_colour_first, .out_colour_second, .out_colour_third,
    .out_class_index, .out_last_pixel_out, .fail_count, .words_in_flight
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic palette_access(input bit wr, input int idx, input pal_word_t value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = CfgAddrW'(idx * 8);
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic send_pixel(input logic [63:0] lo, input logic [63:0] hi,
                            input logic last, input int gap);
    @(negedge clk);
    start          = 1'b1;
    in_scores_low  = lo;
    in_scores_high = hi;
    in_last_pixel  = last;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // wait for every predicted word, then let the pipe run dry
  task automatic settle_pixels();
    @(negedge clk);
    start = 1'b0;
    while (words_in_flight != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic make_pixel(output logic [63:0] lo, output logic [63:0] hi);
    logic signed [7:0] top;
    logic signed [7:0] v;
    logic [7:0]        s;
    int                mode;
    mode = $urandom_range(0, 9);
    top  = 8'($urandom_range(0, 255));
    for (int k = 0; k < MaxClasses; k++) begin
      v = 8'($urandom_range(0, 255));
      case (mode)
        0, 1, 2: s = v;
        // capped at a common top so ties land on random classes
        3, 4:    s = (v > top) ? top : v;
        5, 6:    s = ExtremeScores[$urandom_range(0, 5)];
        7:       s = top;
        default: s = top + 8'($urandom_range(0, 1));
      endcase
      if (k < 8) lo[8*k +: 8] = s;
      else hi[8*(k-8) +: 8] = s;
    end
  endtask

  initial begin
    logic [63:0] lo;
    logic [63:0] hi;
    pal_word_t   word;
    bit          steady;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // palette comes out of reset at zero
    for (int w = 0; w < PalWords; w++) palette_access(1'b0, w, '0);
    send_pixel(DirLow[5], DirHigh[5], 1'b0, 0);
    send_pixel(DirLow[4], DirHigh[4], 1'b1, 2);
    settle_pixels();

    // distinct byte per palette slot so the colour shows the class
    for (int w = 0; w < PalWords; w++) begin
      for (int j = 0; j < 8; j++) word[8*j +: 8] = 8'(8*w + j) ^ 8'ha5;
      palette_access(1'b1, w, word);
    end
    for (int i = 0; i < NumDirected; i++)
      send_pixel(DirLow[i], DirHigh[i], 1'(i % 2), (i < 8) ? 0 : pick_gap(1'b0));

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle_pixels();
      for (int w = 0; w < PalWords; w++) begin
        case (ph)
          0:       word = '1;
          3:       word = '0;
          default: word = {$urandom, $urandom};
        endcase
        palette_access(1'b1, w, word);
      end
      if (ph == 0) begin
        // out of range words must leave the palette alone
        palette_access(1'b1, PalWords, {$urandom, $urandom});
        palette_access(1'b1, PalWords + 1, '1);
      end
      for (int w = 0; w < PalWords; w++) palette_access(1'b0, w, '0);
      steady = 1'b0;
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        make_pixel(lo, hi);
        send_pixel(lo, hi, $urandom_range(0, 7) == 0, pick_gap(steady));
      end
    end

    settle_pixels();
    if (fail_count == 0 && words_in_flight == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/acpc_pkg.sv
src/acpc_cfg_regs.sv
src/acpc_argmax.sv
src/acpc_palette_lut.sv
src/argmax_class_palette_colorizer.sv
src/acpc_checker.sv
verif/acpc_checker.sv
verif/tb.sv
